// ===== rtl/gaussian_polar_sampler_defines.svh =====
// ---------------------------------------------------------------------------
// gaussian polar sampler assertion macros
// shared property shorthands for the sampler's checks
// ---------------------------------------------------------------------------
`ifndef GAUSSIAN_POLAR_SAMPLER_DEFINES_SVH
`define GAUSSIAN_POLAR_SAMPLER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GPS_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, checked outside reset
`define GPS_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/gps_pkg.sv =====
// ---------------------------------------------------------------------------
// gps_pkg
// constants, types and arithmetic helpers of the polar gaussian sampler
// ---------------------------------------------------------------------------
package gps_pkg;

  localparam int UNIFORM_BITS     = 31;
  localparam int SAMPLE_FRAC_BITS = 27;
  localparam int SAMPLE_W         = 32;

  localparam int U_FRAC  = 30;
  localparam int UMAG_W  = U_FRAC + 1;        // |u| <= 1.0 in q1.30
  localparam int FQ_W    = U_FRAC + 1;
  localparam int FR_W    = 34;
  localparam int SQ_W    = 2 * U_FRAC + 1;    // u^2 <= 1.0 in q.60
  localparam int SUM_W   = SQ_W + 1;
  localparam int S_W     = 2 * U_FRAC;        // kept sum is below 1.0
  localparam int MANT_W  = 63;
  localparam int NZ_W    = 6;
  localparam int LOG_FRAC    = 56;
  localparam int SQR_ROUNDS  = LOG_FRAC;
  localparam int NORM_STAGES = 3;
  localparam int NEGLOG_W    = 62;
  localparam int LOG_LAT     = NORM_STAGES + 2 * SQR_ROUNDS + 1;
  localparam int RAD_W       = 64;
  localparam int ROOT_W      = 32;
  localparam int ROOT_STEPS  = 32;
  localparam int Q_W         = 32;
  localparam int DIV_STEPS   = Q_W;
  localparam int PRE_LAT     = 4;
  localparam int MUL_LAT     = 2;
  localparam int OUT_LAT     = 2;
  localparam int PIPE_DEPTH  = PRE_LAT + LOG_LAT + MUL_LAT + ROOT_STEPS + OUT_LAT;
  localparam int R_DELAY     = LOG_LAT + MUL_LAT - DIV_STEPS;
  localparam int SHIFT       = 59 - SAMPLE_FRAC_BITS;

  localparam logic [62:0] LN2_Q63 = 63'h58B9_0BFB_E8E7_BCD6;

  typedef struct packed {
    logic [FQ_W-1:0] q;
    logic [FR_W-1:0] r;
    logic            neg;
  } fold_t;

  typedef struct packed {
    logic [UMAG_W-1:0] u1;
    logic [UMAG_W-1:0] u2;
    logic              n1;
    logic              n2;
  } pair_t;

  typedef struct packed {
    logic [Q_W-1:0] r1;
    logic [Q_W-1:0] r2;
    logic           n1;
    logic           n2;
  } ratio_t;

  // distance from midscale, scaled to q.30, first fold of the divide by rmax
  function automatic fold_t unit_fold(input logic [UNIFORM_BITS-1:0] x);
    logic [63:0] rmax;
    logic [63:0] x2;
    logic [63:0] d;
    logic [63:0] n;
    fold_t       o;
    rmax = (64'd1 << UNIFORM_BITS) - 64'd1;
    x2   = 64'(x) << 1;
    if (x2 >= rmax) begin
      d     = x2 - rmax;
      o.neg = 1'b0;
    end else begin
      d     = rmax - x2;
      o.neg = 1'b1;
    end
    n   = (d << U_FRAC) + (rmax >> 1);
    o.q = FQ_W'(n >> UNIFORM_BITS);
    o.r = FR_W'((n & rmax) + (n >> UNIFORM_BITS));
    return o;
  endfunction

  // remaining folds for a 2^k-1 divisor, then one correction
  function automatic logic [UMAG_W-1:0] unit_finish(input fold_t f);
    logic [63:0] rmax;
    logic [63:0] q;
    logic [63:0] r;
    rmax = (64'd1 << UNIFORM_BITS) - 64'd1;
    q    = 64'(f.q);
    r    = 64'(f.r);
    for (int i = 0; i < 2; i++) begin
      q = q + (r >> UNIFORM_BITS);
      r = (r & rmax) + (r >> UNIFORM_BITS);
    end
    if (r >= rmax) begin
      q = q + 64'd1;
    end
    return UMAG_W'(q);
  endfunction

  // round to output scale, saturate, apply sign
  function automatic logic signed [SAMPLE_W-1:0] make_sample(input logic [63:0] raw,
                                                             input logic neg);
    logic [63:0]         mag;
    logic [SAMPLE_W-1:0] res;
    mag = (raw + (64'd1 << (SHIFT - 1))) >> SHIFT;
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        res = 32'h8000_0000;
      end else begin
        res = SAMPLE_W'(64'd0 - mag);
      end
    end else begin
      if (mag > 64'h7FFF_FFFF) begin
        res = 32'h7FFF_FFFF;
      end else begin
        res = mag[SAMPLE_W-1:0];
      end
    end
    return signed'(res);
  endfunction

endpackage

// ===== rtl/gps_isqrt.sv =====
// ---------------------------------------------------------------------------
// gps_isqrt
// pipelined integer square root, one result bit per stage
// ---------------------------------------------------------------------------
module gps_isqrt import gps_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  radicand,
  output logic [ROOT_W-1:0] root
);

  logic [RAD_W-1:0] v   [ROOT_STEPS];
  logic [RAD_W-1:0] res [ROOT_STEPS];

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * k);
    logic [RAD_W-1:0] vi;
    logic [RAD_W-1:0] ri;
    logic [RAD_W-1:0] trial;

    if (k == 0) begin : g_src
      assign vi = radicand;
      assign ri = '0;
    end else begin : g_src
      assign vi = v[k-1];
      assign ri = res[k-1];
    end

    assign trial = ri + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (vi >= trial) begin
          v[k]   <= vi - trial;
          res[k] <= (ri >> 1) + BIT;
        end else begin
          v[k]   <= vi;
          res[k] <= ri >> 1;
        end
      end
    end
  end

  assign root = res[ROOT_STEPS-1][ROOT_W-1:0];

endmodule

// ===== rtl/gps_neglog.sv =====
// ---------------------------------------------------------------------------
// gps_neglog
// pipelined -log2 of the q.60 sum: normalize, then one fraction bit per
// squaring round, each round split into a product stage and a sum stage
// ---------------------------------------------------------------------------
module gps_neglog import gps_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [S_W-1:0]      s_in,
  output logic [NEGLOG_W-1:0] neglog
);

  typedef struct packed {
    logic [NZ_W-1:0]   z;
    logic [MANT_W-1:0] v;
  } norm_t;

  function automatic norm_t norm_step(input norm_t a, input int step);
    norm_t o;
    o = a;
    if ((a.v >> (MANT_W - step)) == '0) begin
      o.v = a.v << step;
      o.z = a.z + NZ_W'(step);
    end
    return o;
  endfunction

  norm_t nrm [NORM_STAGES];
  norm_t nrm_in;

  assign nrm_in = '{z: '0, v: MANT_W'(s_in)};

  always_ff @(posedge clk) begin
    if (en) begin
      nrm[0] <= norm_step(norm_step(nrm_in, 32), 16);
      nrm[1] <= norm_step(norm_step(nrm[0], 8), 4);
      nrm[2] <= norm_step(norm_step(nrm[1], 2), 1);
    end
  end

  // partial products of each round
  logic [61:0]         p_hh [SQR_ROUNDS];
  logic [62:0]         p_hl [SQR_ROUNDS];
  logic [63:0]         p_ll [SQR_ROUNDS];
  logic [NZ_W-1:0]     p_z  [SQR_ROUNDS];
  logic [LOG_FRAC-1:0] p_f  [SQR_ROUNDS];
  // mantissa after each round
  logic [MANT_W-1:0]   m    [SQR_ROUNDS];
  logic [NZ_W-1:0]     m_z  [SQR_ROUNDS];
  logic [LOG_FRAC-1:0] m_f  [SQR_ROUNDS];

  for (genvar r = 0; r < SQR_ROUNDS; r++) begin : g_round
    logic [MANT_W-1:0]   mi;
    logic [NZ_W-1:0]     zi;
    logic [LOG_FRAC-1:0] fi;
    logic [30:0]         mh;
    logic [31:0]         ml;
    logic [125:0]        sq;
    logic [63:0]         t;

    if (r == 0) begin : g_src
      assign mi = nrm[NORM_STAGES-1].v;
      assign zi = nrm[NORM_STAGES-1].z;
      assign fi = '0;
    end else begin : g_src
      assign mi = m[r-1];
      assign zi = m_z[r-1];
      assign fi = m_f[r-1];
    end

    assign mh = mi[62:32];
    assign ml = mi[31:0];

    always_ff @(posedge clk) begin
      if (en) begin
        p_hh[r] <= 62'(mh) * 62'(mh);
        p_hl[r] <= 63'(mh) * 63'(ml);
        p_ll[r] <= 64'(ml) * 64'(ml);
        p_z[r]  <= zi;
        p_f[r]  <= fi;
      end
    end

    // square keeps bits 62 and up, then renormalize into [1,2)
    assign sq = (126'(p_hh[r]) << 64) + (126'(p_hl[r]) << 33) + 126'(p_ll[r]);
    assign t  = sq[125:62];

    always_ff @(posedge clk) begin
      if (en) begin
        m_z[r] <= p_z[r];
        if (t[63]) begin
          m[r]   <= t[63:1];
          m_f[r] <= p_f[r] | (LOG_FRAC'(1) << (LOG_FRAC - 1 - r));
        end else begin
          m[r]   <= t[62:0];
          m_f[r] <= p_f[r];
        end
      end
    end
  end

  // integer part is leading zeros less two
  always_ff @(posedge clk) begin
    if (en) begin
      neglog <= NEGLOG_W'(((64'(m_z[SQR_ROUNDS-1]) - 64'd2) << LOG_FRAC)
                          - 64'(m_f[SQR_ROUNDS-1]));
    end
  end

endmodule

// ===== rtl/gaussian_polar_sampler.sv =====
// ---------------------------------------------------------------------------
// gaussian_polar_sampler
// polar method normal deviates: a pair of raw uniforms in, two q5.27
// samples out, or nothing when the pair falls outside the unit circle
// ---------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------
//  input    | in_valid / in_ready | uniform_first, uniform_second
//  output   | out_valid/out_ready | sample, last
//
//  one pair enters per cycle while the pipeline is not stalled; the depth to
//  the output register is set by the 56 squaring rounds of the log (two
//  stages each) and the 32-stage square root that follows it
//  a kept pair leaves as two beats; a rejected pair takes up an input
//  slot and gives no beat
//  the whole pipeline stalls while a pair at its end waits for the output
//  register to hand over its pair; nothing in flight is dropped or repeated
//  reset clears the valid bits and the output register's valid and phase flags only
// ---------------------------------------------------------------------------
`include "gaussian_polar_sampler_defines.svh"

module gaussian_polar_sampler import gps_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [UNIFORM_BITS-1:0]    uniform_first,
  input  logic [UNIFORM_BITS-1:0]    uniform_second,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] sample,
  output logic                       last
);

  typedef struct packed {
    logic [Q_W:0]   rem1;
    logic [Q_W:0]   rem2;
    logic [Q_W-1:0] q1;
    logic [Q_W-1:0] q2;
    logic [Q_W-1:0] d;
    logic           n1;
    logic           n2;
  } div_t;

  logic                  en;
  logic [PIPE_DEPTH-1:0] vld;
  logic [PIPE_DEPTH-1:0] vld_next;

  // front end: map to q1.30, square, sum
  fold_t              s1_a;
  fold_t              s1_b;
  pair_t              s2_p;
  logic [SQ_W-1:0]    s3_sq1;
  logic [SQ_W-1:0]    s3_sq2;
  pair_t              s3_p;
  logic [S_W-1:0]     s4_s;
  pair_t              s4_p;
  logic [SUM_W-1:0]   sum;
  logic               keep;

  assign sum  = SUM_W'(s3_sq1) + SUM_W'(s3_sq2);
  assign keep = (sum != '0) && (sum < (SUM_W'(1) << S_W));

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a   <= unit_fold(uniform_first);
      s1_b   <= unit_fold(uniform_second);
      s2_p   <= '{u1: unit_finish(s1_a), u2: unit_finish(s1_b), n1: s1_a.neg, n2: s1_b.neg};
      s3_sq1 <= SQ_W'(s2_p.u1) * SQ_W'(s2_p.u1);
      s3_sq2 <= SQ_W'(s2_p.u2) * SQ_W'(s2_p.u2);
      s3_p   <= s2_p;
      s4_s   <= sum[S_W-1:0];
      s4_p   <= s3_p;
    end
  end

  // rejected pairs lose their valid bit at the sum stage
  always_comb begin
    vld_next = {vld[PIPE_DEPTH-2:0], in_valid};
    vld_next[PRE_LAT-1] = vld[PRE_LAT-2] && keep;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= vld_next;
    end
  end

  // -log2 s
  logic [NEGLOG_W-1:0] neglog;

  gps_neglog u_neglog (
    .clk    (clk),
    .en     (en),
    .s_in   (s4_s),
    .neglog (neglog)
  );

  // sqrt(4 s) alongside, with the magnitudes held until it is ready
  logic [ROOT_W-1:0] root_s;
  pair_t             pd [ROOT_STEPS];

  gps_isqrt u_sqrt_s (
    .clk      (clk),
    .en       (en),
    .radicand (RAD_W'({s4_s, 2'b00})),
    .root     (root_s)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      pd[0] <= s4_p;
      for (int i = 1; i < ROOT_STEPS; i++) begin
        pd[i] <= pd[i-1];
      end
    end
  end

  // |u| / sqrt(4 s): the quotient fits in 32 bits, so the remainder starts at |u|
  div_t dv [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    div_t         src;
    logic [Q_W:0] t1;
    logic [Q_W:0] t2;
    logic [Q_W:0] dd;

    if (k == 0) begin : g_src
      assign src = '{rem1: (Q_W + 1)'(pd[ROOT_STEPS-1].u1),
                     rem2: (Q_W + 1)'(pd[ROOT_STEPS-1].u2),
                     q1: '0, q2: '0, d: root_s,
                     n1: pd[ROOT_STEPS-1].n1, n2: pd[ROOT_STEPS-1].n2};
    end else begin : g_src
      assign src = dv[k-1];
    end

    assign t1 = {src.rem1[Q_W-1:0], 1'b0};
    assign t2 = {src.rem2[Q_W-1:0], 1'b0};
    assign dd = {1'b0, src.d};

    always_ff @(posedge clk) begin
      if (en) begin
        dv[k].d  <= src.d;
        dv[k].n1 <= src.n1;
        dv[k].n2 <= src.n2;
        if (t1 >= dd) begin
          dv[k].rem1 <= t1 - dd;
          dv[k].q1   <= {src.q1[Q_W-2:0], 1'b1};
        end else begin
          dv[k].rem1 <= t1;
          dv[k].q1   <= {src.q1[Q_W-2:0], 1'b0};
        end
        if (t2 >= dd) begin
          dv[k].rem2 <= t2 - dd;
          dv[k].q2   <= {src.q2[Q_W-2:0], 1'b1};
        end else begin
          dv[k].rem2 <= t2;
          dv[k].q2   <= {src.q2[Q_W-2:0], 1'b0};
        end
      end
    end
  end

  ratio_t rd [R_DELAY];

  always_ff @(posedge clk) begin
    if (en) begin
      rd[0] <= '{r1: dv[DIV_STEPS-1].q1, r2: dv[DIV_STEPS-1].q2,
                 n1: dv[DIV_STEPS-1].n1, n2: dv[DIV_STEPS-1].n2};
      for (int i = 1; i < R_DELAY; i++) begin
        rd[i] <= rd[i-1];
      end
    end
  end

  // l = -2 ln s = neglog * ln2, split at bit 32 into four partial products
  logic [63:0]  pp_ll;
  logic [62:0]  pp_lh;
  logic [61:0]  pp_hl;
  logic [60:0]  pp_hh;
  logic [125:0] lprod;
  logic [63:0]  lval;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll <= 64'(neglog[31:0])  * 64'(LN2_Q63[31:0]);
      pp_lh <= 63'(neglog[31:0])  * 63'(LN2_Q63[62:32]);
      pp_hl <= 62'(neglog[61:32]) * 62'(LN2_Q63[31:0]);
      pp_hh <= 61'(neglog[61:32]) * 61'(LN2_Q63[62:32]);
    end
  end

  assign lprod = (126'(pp_hh) << 64) + (126'(pp_lh) << 32) + (126'(pp_hl) << 32)
                 + 126'(pp_ll);

  always_ff @(posedge clk) begin
    if (en) begin
      lval <= lprod[125:62];
    end
  end

  logic [ROOT_W-1:0] root_l;

  gps_isqrt u_sqrt_l (
    .clk      (clk),
    .en       (en),
    .radicand (lval),
    .root     (root_l)
  );

  // scale ratio by sqrt(l), then round and sign
  logic [63:0]                raw1;
  logic [63:0]                raw2;
  logic                       raw_n1;
  logic                       raw_n2;
  logic signed [SAMPLE_W-1:0] fs1;
  logic signed [SAMPLE_W-1:0] fs2;

  always_ff @(posedge clk) begin
    if (en) begin
      raw1   <= 64'(rd[R_DELAY-1].r1) * 64'(root_l);
      raw2   <= 64'(rd[R_DELAY-1].r2) * 64'(root_l);
      raw_n1 <= rd[R_DELAY-1].n1;
      raw_n2 <= rd[R_DELAY-1].n2;
      fs1    <= make_sample(raw1, raw_n1);
      fs2    <= make_sample(raw2, raw_n2);
    end
  end

  // output register holds both samples, phase picks the beat
  logic                       hold_valid;
  logic                       hold_phase;
  logic signed [SAMPLE_W-1:0] hold_s1;
  logic signed [SAMPLE_W-1:0] hold_s2;

  assign en = !vld[PIPE_DEPTH-1] || !hold_valid || (out_ready && hold_phase);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      hold_phase <= 1'b0;
    end else if (en && vld[PIPE_DEPTH-1]) begin
      hold_valid <= 1'b1;
      hold_phase <= 1'b0;
    end else if (hold_valid && out_ready) begin
      if (hold_phase) begin
        hold_valid <= 1'b0;
      end else begin
        hold_phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld[PIPE_DEPTH-1]) begin
      hold_s1 <= fs1;
      hold_s2 <= fs2;
    end
  end

  assign in_ready  = en;
  assign out_valid = hold_valid;
  assign sample    = hold_phase ? hold_s2 : hold_s1;
  assign last      = hold_phase;

  `GPS_ASSERT_NEXT(a_second_follows, out_valid && out_ready && !last, out_valid && last, "second sample of a pair missing")
  `GPS_ASSERT_IMPL(a_stall_holds, hold_valid && !(out_ready && last) && vld[PIPE_DEPTH-1], !in_ready, "pipeline advanced over a waiting pair")
  `GPS_ASSERT_NEXT(a_pair_enters, in_valid && in_ready, vld[0], "accepted beat not in pipeline")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb - polar gaussian sampler testbench
// drives uniform pairs under random back-pressure and checks every output
// beat against an independent fixed-point model of the polar method
// ---------------------------------------------------------------------------
module tb;
  import gps_pkg::*;

  localparam int N_RANDOM   = 1430;
  localparam int LIMIT      = 400000;
  localparam int DRAIN      = 400;
  localparam int HOLD_LEN   = 600;
  localparam logic [30:0] UMAX = 31'h7FFF_FFFF;
  localparam logic [30:0] UMID = 31'h4000_0000;

  typedef enum logic [0:0] {ROW_CHECK, ROW_REJECT} row_kind_t;

  typedef struct {
    logic [30:0] a;
    logic [30:0] b;
    row_kind_t   kind;
  } pair_row_t;

  typedef struct {
    logic signed [31:0] value;
    logic               is_last;
  } deviate_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [UNIFORM_BITS-1:0] uniform_first;
  logic [UNIFORM_BITS-1:0] uniform_second;
  logic out_valid;
  logic out_ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic last;

  deviate_t pending_deviates[$];
  int errors;
  int cycles;
  int pairs_sent;
  int idle_in_pct;
  int idle_out_pct;
  bit hold_done;

  gaussian_polar_sampler DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .uniform_first(uniform_first), .uniform_second(uniform_second),
    .out_valid(out_valid), .out_ready(out_ready),
    .sample(sample), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] unit_mag(input logic [30:0] x, output logic neg);
    logic [63:0] rmax;
    logic [63:0] d;
    rmax = 64'h7FFF_FFFF;
    if ({32'd0, x, 1'b0} >= rmax) begin
      d   = {32'd0, x, 1'b0} - rmax;
      neg = 1'b0;
    end else begin
      d   = rmax - {32'd0, x, 1'b0};
      neg = 1'b1;
    end
    return ((d << 30) + (rmax >> 1)) / rmax;
  endfunction

  function automatic logic signed [31:0] scale_deviate(input logic [63:0] umag, input logic neg,
                                                      input logic [63:0] root_s,
                                                      input logic [63:0] root_l);
    logic [63:0] ratio;
    logic [63:0] raw;
    logic [63:0] mag;
    if (root_s == 0) return 32'sd0;
    ratio = (umag << 32) / root_s;
    raw   = ratio * root_l;
    mag   = (raw + (64'd1 << (SHIFT - 1))) >> SHIFT;
    if (neg) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      return signed'(32'(64'd0 - mag));
    end
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return signed'(mag[31:0]);
  endfunction

  // returns the number of deviates queued for this pair: 0 or 2
  function automatic int predict_deviates(input logic [30:0] a, input logic [30:0] b);
    logic n1;
    logic n2;
    logic [63:0] u1;
    logic [63:0] u2;
    logic [63:0] s;
    logic [63:0] m;
    logic [63:0] frac;
    logic [63:0] neglog;
    logic [63:0] lval;
    logic [63:0] root_l;
    logic [63:0] root_s;
    logic [127:0] prod;
    int p;
    deviate_t d;
    u1 = unit_mag(a, n1);
    u2 = unit_mag(b, n2);
    s  = u1 * u1 + u2 * u2;
    if (s == 0 || s >= (64'd1 << 60)) return 0;
    p = 59;
    while (p > 0 && s[p] == 1'b0) p--;
    m    = s << (62 - p);
    frac = 64'd0;
    // fraction of -log2 by repeated squaring of the mantissa
    for (int i = 55; i >= 0; i--) begin
      prod = {64'd0, m} * {64'd0, m};
      m    = 64'(prod >> 62);
      if (m[63]) begin
        m       = m >> 1;
        frac[i] = 1'b1;
      end
    end
    neglog = (64'(60 - p) << 56) - frac;
    prod   = {64'd0, neglog} * {65'd0, LN2_Q63};
    lval   = 64'(prod >> 62);
    root_l = int_sqrt(lval);
    root_s = int_sqrt(s << 2);
    d.value   = scale_deviate(u1, n1, root_s, root_l);
    d.is_last = 1'b0;
    pending_deviates.push_back(d);
    d.value   = scale_deviate(u2, n2, root_s, root_l);
    d.is_last = 1'b1;
    pending_deviates.push_back(d);
    return 2;
  endfunction

  // beat monitor
  always @(posedge clk) begin
    deviate_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        void'(predict_deviates(uniform_first, uniform_second));
      end
      if (out_valid && out_ready) begin
        if (pending_deviates.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat sample=%0d last=%0b", $time, sample, last);
        end else begin
          want = pending_deviates.pop_front();
          if (sample !== want.value) begin
            errors++;
            $display("%0t: sample expected %0d actual %0d", $time, want.value, sample);
          end
          if (last !== want.is_last) begin
            errors++;
            $display("%0t: last expected %0b actual %0b", $time, want.is_last, last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off to back up the pipe
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!hold_done && pairs_sent >= 120) begin
        hold_done = 1'b1;
        out_ready = 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end
      out_ready = ($urandom_range(99) >= idle_out_pct);
    end
  end

  task automatic send_pair(input logic [30:0] a, input logic [30:0] b);
    while ($urandom_range(99) < idle_in_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    uniform_first  = a;
    uniform_second = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pairs_sent++;
    @(negedge clk);
  endtask

  function automatic logic [30:0] pick_uniform();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return 31'($urandom);
    if (sel < 85) return UMID + 31'($urandom_range(4000)) - 31'd2000;
    if (sel < 90) return 31'd0;
    if (sel < 95) return UMAX;
    return 31'($urandom_range(2000)) << $urandom_range(20);
  endfunction

  pair_row_t pair_rows[$];

  initial begin
    int want_count;
    rst            = 1'b1;
    in_valid       = 1'b0;
    uniform_first  = '0;
    uniform_second = '0;
    errors         = 0;
    cycles         = 0;
    pairs_sent     = 0;
    hold_done      = 1'b0;
    idle_in_pct    = 11;
    idle_out_pct   = 61;

    // corners: both ends of the range are outside the circle, as is one diagonal point
    pair_rows.push_back('{31'd0,     31'd0,     ROW_REJECT});
    pair_rows.push_back('{UMAX,      UMAX,      ROW_REJECT});
    pair_rows.push_back('{31'd0,     UMAX,      ROW_REJECT});
    pair_rows.push_back('{UMAX,      UMID,      ROW_REJECT});
    pair_rows.push_back('{UMID,      31'd0,     ROW_REJECT});
    pair_rows.push_back('{31'h6E00_0000, 31'h6E00_0000, ROW_REJECT});
    // near midscale: tiny sum, largest deviates
    pair_rows.push_back('{UMID,      UMID,      ROW_CHECK});
    pair_rows.push_back('{UMID - 31'd1,  UMID,  ROW_CHECK});
    pair_rows.push_back('{UMID - 31'd1,  UMID - 31'd1,  ROW_CHECK});
    pair_rows.push_back('{UMID + 31'd1,  UMID - 31'd2,  ROW_CHECK});
    pair_rows.push_back('{UMID + 31'd1000, UMID, ROW_CHECK});
    // one axis near the edge, the other centered
    pair_rows.push_back('{31'd1,     UMID,      ROW_CHECK});
    pair_rows.push_back('{UMAX - 31'd1,  UMID,  ROW_CHECK});
    pair_rows.push_back('{UMID,      31'd1,     ROW_CHECK});
    pair_rows.push_back('{UMID,      UMAX - 31'd1,  ROW_CHECK});
    // one point just inside the unit circle on the diagonal, then points well inside
    pair_rows.push_back('{31'h6D00_0000, 31'h6D00_0000, ROW_CHECK});
    pair_rows.push_back('{31'h257D_8670, 31'h257D_8670, ROW_CHECK});
    pair_rows.push_back('{31'h2000_0000, 31'h6000_0000, ROW_CHECK});
    pair_rows.push_back('{31'h5555_5555, 31'h2AAA_AAAA, ROW_CHECK});
    pair_rows.push_back('{31'h3FFF_0000, 31'h4000_FFFF, ROW_CHECK});

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (pair_rows[i]) begin
      if (pair_rows[i].kind == ROW_REJECT) begin
        want_count = predict_deviates(pair_rows[i].a, pair_rows[i].b);
        if (want_count != 0) begin
          errors++;
          $display("%0t: row %0d expected reject, model kept it", $time, i);
          repeat (want_count) void'(pending_deviates.pop_back());
        end
      end
      send_pair(pair_rows[i].a, pair_rows[i].b);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) begin
        idle_in_pct  = 61;
        idle_out_pct = 11;
      end else if (n == 2 * N_RANDOM / 3) begin
        idle_in_pct  = 0;
        idle_out_pct = 0;
      end
      send_pair(pick_uniform(), pick_uniform());
    end
    in_valid = 1'b0;

    while (pending_deviates.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/gps_pkg.sv
rtl/gps_isqrt.sv
rtl/gps_neglog.sv
rtl/gaussian_polar_sampler.sv
tb/tb.sv
